[rtl/tlnt_pkg.sv]
package tlnt_pkg;

    // Default table dimensions.
    localparam int unsigned DEF_MAX_DIRS  = 16;
    localparam int unsigned DEF_MAX_FILES = 32;

    localparam int unsigned KEY_W    = 64;
    localparam int unsigned OP_W     = 2;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned SLOT_W   = 4;
    localparam int unsigned FCOUNT_W = 6;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_CREATE_DIR  = 2'd0;
    localparam logic [OP_W-1:0] OP_CREATE_FILE = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE_FILE = 2'd2;
    localparam logic [OP_W-1:0] OP_SEARCH_FILE = 2'd3;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
    localparam logic [STATUS_W-1:0] ST_TABLE_FULL   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DIR_EXISTS   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DIR_MISSING  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FILE_EXISTS  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FILE_MISSING = 3'd5;
    localparam logic [STATUS_W-1:0] ST_DIR_FULL     = 3'd6;

    typedef struct packed {
        logic [OP_W-1:0]  operation;
        logic [KEY_W-1:0] dir_key;
        logic [KEY_W-1:0] file_key;
    } tlnt_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   dir_slot;
        logic [FCOUNT_W-1:0] files_in_dir;
    } tlnt_rsp_t;

    // Bits needed to index n entries, at least one.
    function automatic int unsigned idx_w(input int unsigned n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

endpackage

[rtl/two_level_name_table.sv]
// Two-level name table: directory keys, each with a dense list of file keys.
//
// Request channel (req_valid, req_stall, req): one transaction carries an
// operation (create directory, create file, delete file, search file), a
// directory key and a file key. Response channel (rsp_valid, rsp_stall, rsp):
// exactly one transaction per request, in order, with a status code, the
// directory slot and the directory's file count after the operation.
//
// One request is processed at a time. The sequencer compares directory
// keys, then the matched directory's file keys, one per cycle out of each
// memory (up to MAX_DIRS and MAX_FILES). Create directory and a missing
// directory skip the file scan; a delete that finds its file adds a move
// step. The sequencer returns to idle before it takes the next request.
//
// Reset clears the directory count and the control state; memory contents
// are never read before they are written. A stalled response waits in the
// output register while the next request is already being processed; a
// finished request waits for that register to drain before the next request
// is accepted.
module two_level_name_table
    import tlnt_pkg::*;
#(
    parameter int unsigned MAX_DIRS  = DEF_MAX_DIRS,
    parameter int unsigned MAX_FILES = DEF_MAX_FILES
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  tlnt_req_t req,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output tlnt_rsp_t rsp
);

    localparam int unsigned SW  = idx_w(MAX_DIRS);
    localparam int unsigned FAW = idx_w(MAX_DIRS * MAX_FILES);
    localparam int unsigned CW  = $clog2(MAX_FILES + 1);

    logic             busy;
    logic             out_free;
    logic             done;
    tlnt_rsp_t        result;
    logic [SW-1:0]    dir_raddr;
    logic             dir_we;
    logic [SW-1:0]    dir_waddr;
    logic [KEY_W-1:0] dir_wname;
    logic [CW-1:0]    dir_wcount;
    logic [KEY_W-1:0] dir_rname;
    logic [CW-1:0]    dir_rcount;
    logic [FAW-1:0]   file_raddr;
    logic             file_we;
    logic [FAW-1:0]   file_waddr;
    logic [KEY_W-1:0] file_wdata;
    logic [KEY_W-1:0] file_rdata;

    logic             rsp_valid_reg, rsp_valid_next;
    tlnt_rsp_t        rsp_reg;

    tlnt_dir_store #(
        .MAX_DIRS  (MAX_DIRS),
        .MAX_FILES (MAX_FILES)
    ) u_dir_store (
        .clk    (clk),
        .raddr  (dir_raddr),
        .we     (dir_we),
        .waddr  (dir_waddr),
        .wname  (dir_wname),
        .wcount (dir_wcount),
        .rname  (dir_rname),
        .rcount (dir_rcount)
    );

    tlnt_file_store #(
        .MAX_DIRS  (MAX_DIRS),
        .MAX_FILES (MAX_FILES)
    ) u_file_store (
        .clk   (clk),
        .raddr (file_raddr),
        .we    (file_we),
        .waddr (file_waddr),
        .wdata (file_wdata),
        .rdata (file_rdata)
    );

    tlnt_ctrl #(
        .MAX_DIRS  (MAX_DIRS),
        .MAX_FILES (MAX_FILES)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req        (req),
        .busy       (busy),
        .out_free   (out_free),
        .done       (done),
        .result     (result),
        .dir_raddr  (dir_raddr),
        .dir_we     (dir_we),
        .dir_waddr  (dir_waddr),
        .dir_wname  (dir_wname),
        .dir_wcount (dir_wcount),
        .dir_rname  (dir_rname),
        .dir_rcount (dir_rcount),
        .file_raddr (file_raddr),
        .file_we    (file_we),
        .file_waddr (file_waddr),
        .file_wdata (file_wdata),
        .file_rdata (file_rdata)
    );

    // The sequencer only takes a new request when it is idle.
    assign req_stall = busy;

    // The output register can take a new response when it is empty or
    // its current response leaves at this edge.
    assign out_free = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (done)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            rsp_reg <= result;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

[rtl/tlnt_dir_store.sv]
// Directory store: one key and one file count per directory slot.
module tlnt_dir_store
    import tlnt_pkg::*;
#(
    parameter int unsigned MAX_DIRS  = DEF_MAX_DIRS,
    parameter int unsigned MAX_FILES = DEF_MAX_FILES
)
(
    input  logic                                clk,
    input  logic [idx_w(MAX_DIRS)-1:0]          raddr,
    input  logic                                we,
    input  logic [idx_w(MAX_DIRS)-1:0]          waddr,
    input  logic [KEY_W-1:0]                    wname,
    input  logic [$clog2(MAX_FILES+1)-1:0]      wcount,
    output logic [KEY_W-1:0]                    rname,
    output logic [$clog2(MAX_FILES+1)-1:0]      rcount
);

    localparam int unsigned CW = $clog2(MAX_FILES + 1);

    logic [KEY_W-1:0] name_mem  [MAX_DIRS];
    logic [CW-1:0]    count_mem [MAX_DIRS];
    logic [KEY_W-1:0] rname_reg;
    logic [CW-1:0]    rcount_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            name_mem[waddr]  <= wname;
            count_mem[waddr] <= wcount;
        end
        rname_reg  <= name_mem[raddr];
        rcount_reg <= count_mem[raddr];
    end

    assign rname  = rname_reg;
    assign rcount = rcount_reg;

endmodule

[rtl/tlnt_file_store.sv]
// File key store: MAX_FILES consecutive entries per directory slot.
module tlnt_file_store
    import tlnt_pkg::*;
#(
    parameter int unsigned MAX_DIRS  = DEF_MAX_DIRS,
    parameter int unsigned MAX_FILES = DEF_MAX_FILES
)
(
    input  logic                                   clk,
    input  logic [idx_w(MAX_DIRS*MAX_FILES)-1:0]   raddr,
    input  logic                                   we,
    input  logic [idx_w(MAX_DIRS*MAX_FILES)-1:0]   waddr,
    input  logic [KEY_W-1:0]                       wdata,
    output logic [KEY_W-1:0]                       rdata
);

    localparam int unsigned DEPTH = MAX_DIRS * MAX_FILES;

    logic [KEY_W-1:0] key_mem [DEPTH];
    logic [KEY_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            key_mem[waddr] <= wdata;
        end
        rdata_reg <= key_mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/tlnt_ctrl.sv]
// Sequencer: scans the directory store, then the chosen directory's files,
// and applies the operation with read-modify-write on both stores.
module tlnt_ctrl
    import tlnt_pkg::*;
#(
    parameter int unsigned MAX_DIRS  = DEF_MAX_DIRS,
    parameter int unsigned MAX_FILES = DEF_MAX_FILES
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   req_valid,
    input  tlnt_req_t                              req,
    output logic                                   busy,
    input  logic                                   out_free,
    output logic                                   done,
    output tlnt_rsp_t                              result,
    output logic [idx_w(MAX_DIRS)-1:0]             dir_raddr,
    output logic                                   dir_we,
    output logic [idx_w(MAX_DIRS)-1:0]             dir_waddr,
    output logic [KEY_W-1:0]                       dir_wname,
    output logic [$clog2(MAX_FILES+1)-1:0]         dir_wcount,
    input  logic [KEY_W-1:0]                       dir_rname,
    input  logic [$clog2(MAX_FILES+1)-1:0]         dir_rcount,
    output logic [idx_w(MAX_DIRS*MAX_FILES)-1:0]   file_raddr,
    output logic                                   file_we,
    output logic [idx_w(MAX_DIRS*MAX_FILES)-1:0]   file_waddr,
    output logic [KEY_W-1:0]                       file_wdata,
    input  logic [KEY_W-1:0]                       file_rdata
);

    localparam int unsigned SW  = idx_w(MAX_DIRS);
    localparam int unsigned FW  = idx_w(MAX_FILES);
    localparam int unsigned FAW = idx_w(MAX_DIRS * MAX_FILES);
    localparam int unsigned CW  = $clog2(MAX_FILES + 1);
    localparam int unsigned DCW = $clog2(MAX_DIRS + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DSCAN = 3'd1;
    localparam logic [2:0] S_DDEC  = 3'd2;
    localparam logic [2:0] S_FSCAN = 3'd3;
    localparam logic [2:0] S_FDEC  = 3'd4;
    localparam logic [2:0] S_MOVE  = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0]          state_reg, state_next;
    logic [DCW-1:0]      dir_count_reg, dir_count_next;
    logic [OP_W-1:0]     op_reg, op_next;
    logic [KEY_W-1:0]    dkey_reg, dkey_next;
    logic [KEY_W-1:0]    fkey_reg, fkey_next;
    logic [SW-1:0]       idx_reg, idx_next;
    logic                found_reg, found_next;
    logic                hit_reg, hit_next;
    logic [SW-1:0]       slot_reg, slot_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [FW-1:0]       fidx_reg, fidx_next;
    logic [FAW-1:0]      base_reg, base_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [FAW-1:0]      base_calc;

    // Constant multiply; the product always stays below the store depth.
    assign base_calc = FAW'(slot_reg) * FAW'(MAX_FILES);

    always_comb
    begin
        state_next     = state_reg;
        dir_count_next = dir_count_reg;
        op_next        = op_reg;
        dkey_next      = dkey_reg;
        fkey_next      = fkey_reg;
        idx_next       = idx_reg;
        found_next     = found_reg;
        hit_next       = hit_reg;
        slot_next      = slot_reg;
        count_next     = count_reg;
        fidx_next      = fidx_reg;
        base_next      = base_reg;
        status_next    = status_reg;
        dir_raddr      = '0;
        dir_we         = 1'b0;
        dir_waddr      = slot_reg;
        dir_wname      = dkey_reg;
        dir_wcount     = count_reg;
        file_raddr     = base_reg;
        file_we        = 1'b0;
        file_waddr     = base_reg;
        file_wdata     = fkey_reg;
        done           = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    op_next    = req.operation;
                    dkey_next  = req.dir_key;
                    fkey_next  = req.file_key;
                    idx_next   = '0;
                    found_next = 1'b0;
                    hit_next   = 1'b0;
                    slot_next  = '0;
                    count_next = '0;
                    state_next = (dir_count_reg == '0) ? S_DDEC : S_DSCAN;
                end
            end
            S_DSCAN:
            begin
                // Read data belongs to directory idx_reg.
                if (dir_rname == dkey_reg)
                begin
                    found_next = 1'b1;
                    slot_next  = idx_reg;
                    count_next = dir_rcount;
                    state_next = S_DDEC;
                end
                else if (DCW'(idx_reg) + DCW'(1) < dir_count_reg)
                begin
                    idx_next  = idx_reg + SW'(1);
                    dir_raddr = idx_reg + SW'(1);
                end
                else
                begin
                    state_next = S_DDEC;
                end
            end
            S_DDEC:
            begin
                base_next = base_calc;
                fidx_next = '0;
                if (op_reg == OP_CREATE_DIR)
                begin
                    state_next = S_DONE;
                    if (dir_count_reg >= DCW'(MAX_DIRS))
                    begin
                        status_next = ST_TABLE_FULL;
                        slot_next   = '0;
                        count_next  = '0;
                    end
                    else if (found_reg)
                    begin
                        status_next = ST_DIR_EXISTS;
                    end
                    else
                    begin
                        dir_we         = 1'b1;
                        dir_waddr      = SW'(dir_count_reg);
                        dir_wcount     = '0;
                        dir_count_next = dir_count_reg + DCW'(1);
                        slot_next      = SW'(dir_count_reg);
                        count_next     = '0;
                        status_next    = ST_OK;
                    end
                end
                else if (!found_reg)
                begin
                    status_next = ST_DIR_MISSING;
                    state_next  = S_DONE;
                end
                else if (count_reg == '0)
                begin
                    state_next = S_FDEC;
                end
                else
                begin
                    file_raddr = base_calc;
                    state_next = S_FSCAN;
                end
            end
            S_FSCAN:
            begin
                // Read data belongs to file fidx_reg of the matched directory.
                if (file_rdata == fkey_reg)
                begin
                    hit_next   = 1'b1;
                    state_next = S_FDEC;
                end
                else if (CW'(fidx_reg) + CW'(1) < count_reg)
                begin
                    fidx_next  = fidx_reg + FW'(1);
                    file_raddr = base_reg + FAW'(fidx_reg) + FAW'(1);
                end
                else
                begin
                    state_next = S_FDEC;
                end
            end
            S_FDEC:
            begin
                state_next = S_DONE;
                unique case (op_reg)
                    OP_CREATE_FILE:
                    begin
                        if (hit_reg)
                        begin
                            status_next = ST_FILE_EXISTS;
                        end
                        else if (count_reg >= CW'(MAX_FILES))
                        begin
                            status_next = ST_DIR_FULL;
                        end
                        else
                        begin
                            file_we     = 1'b1;
                            file_waddr  = base_reg + FAW'(count_reg);
                            dir_we      = 1'b1;
                            dir_wcount  = count_reg + CW'(1);
                            count_next  = count_reg + CW'(1);
                            status_next = ST_OK;
                        end
                    end
                    OP_DELETE_FILE:
                    begin
                        if (!hit_reg)
                        begin
                            status_next = ST_FILE_MISSING;
                        end
                        else
                        begin
                            // Fetch the last file; it fills the freed slot next cycle.
                            dir_we      = 1'b1;
                            dir_wcount  = count_reg - CW'(1);
                            count_next  = count_reg - CW'(1);
                            file_raddr  = base_reg + FAW'(count_reg - CW'(1));
                            status_next = ST_OK;
                            state_next  = S_MOVE;
                        end
                    end
                    default:
                    begin
                        status_next = hit_reg ? ST_OK : ST_FILE_MISSING;
                    end
                endcase
            end
            S_MOVE:
            begin
                file_we    = 1'b1;
                file_waddr = base_reg + FAW'(fidx_reg);
                file_wdata = file_rdata;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    done       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            dir_count_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            dir_count_reg <= dir_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        dkey_reg   <= dkey_next;
        fkey_reg   <= fkey_next;
        idx_reg    <= idx_next;
        found_reg  <= found_next;
        hit_reg    <= hit_next;
        slot_reg   <= slot_next;
        count_reg  <= count_next;
        fidx_reg   <= fidx_next;
        base_reg   <= base_next;
        status_reg <= status_next;
    end

    assign busy                = (state_reg != S_IDLE);
    assign result.status       = status_reg;
    assign result.dir_slot     = SLOT_W'(slot_reg);
    assign result.files_in_dir = FCOUNT_W'(count_reg);

    // The directory count never passes the table size.
    a_dir_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        dir_count_reg <= DCW'(MAX_DIRS))
        else $error("directory count beyond table size");

    // The directory count only grows, one step at a time.
    a_dir_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        dir_count_reg != $past(dir_count_reg) |->
            dir_count_reg == $past(dir_count_reg) + DCW'(1))
        else $error("directory count changed by other than one");

    // The directory scan stays inside the populated slots.
    a_dscan_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DSCAN |-> DCW'(idx_reg) < dir_count_reg)
        else $error("directory scan past last directory");

    // The file scan stays inside the directory's stored files.
    a_fscan_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FSCAN |-> CW'(fidx_reg) < count_reg)
        else $error("file scan past last file");

    // A file is only appended to a directory with room left.
    a_append_room: assert property (@(posedge clk) disable iff (!rst_n)
        file_we && state_reg == S_FDEC |-> count_reg < CW'(MAX_FILES))
        else $error("file appended to a full directory");

endmodule

[bench/two_level_name_table_tb.sv]
`timescale 1ns / 100ps

// Self-checking bench for the two-level name table.
module two_level_name_table_tb;

    import tlnt_pkg::*;

    localparam int unsigned TB_MAX_DIRS  = DEF_MAX_DIRS;
    localparam int unsigned TB_MAX_FILES = DEF_MAX_FILES;
    localparam int unsigned POOL_SIZE    = 48;

    // Every input starts at a known value. The request side is driven by the
    // send task and the response stall by its own generator further down.
    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_stall;
    tlnt_req_t req       = '0;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    tlnt_rsp_t rsp;

    two_level_name_table
    #(
        .MAX_DIRS  (TB_MAX_DIRS),
        .MAX_FILES (TB_MAX_FILES)
    )
    u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #5 clk = ~clk;

    // Shadow copy of the table. It is updated at the edge that accepts a
    // request, so it always reflects every transaction the block has taken.
    logic [KEY_W-1:0] dir_key_tab [TB_MAX_DIRS];
    logic [KEY_W-1:0] file_key_tab [TB_MAX_DIRS][TB_MAX_FILES];
    int unsigned      file_cnt_tab [TB_MAX_DIRS];
    int unsigned      num_dirs = 0;

    // Responses still owed by the block, oldest first.
    tlnt_rsp_t pending_replies [$];

    // Directory keys created so far, and the file keys the random traffic
    // draws from, so that hits, duplicates and full directories are common.
    logic [KEY_W-1:0] dir_list [$];
    logic [KEY_W-1:0] file_pool [POOL_SIZE];

    int unsigned n_sent = 0;
    int unsigned n_checked = 0;
    int unsigned n_errors = 0;
    int unsigned status_hits [8];
    bit          no_idle = 1'b0;

    function automatic logic [KEY_W-1:0] rand_key();
        return {$urandom, $urandom};
    endfunction

    // Mostly short pauses, now and then a long one.
    function automatic int unsigned pause_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Applies one operation to the shadow table and returns the response it
    // must produce. Lookups take the first equal key in slot order.
    function automatic tlnt_rsp_t run_table_op(input tlnt_req_t r);
        tlnt_rsp_t   res;
        int          d;
        int          f;
        int unsigned n;
        int unsigned i;
        res = '0;
        res.status = ST_OK;
        d = -1;
        f = -1;
        for (i = 0; i < num_dirs; i++)
        begin
            if (d < 0 && dir_key_tab[i] == r.dir_key)
                d = i;
        end
        if (r.operation == OP_CREATE_DIR)
        begin
            // The full check wins over the duplicate check.
            if (num_dirs >= TB_MAX_DIRS)
                res.status = ST_TABLE_FULL;
            else if (d >= 0)
            begin
                res.status       = ST_DIR_EXISTS;
                res.dir_slot     = SLOT_W'(d);
                res.files_in_dir = FCOUNT_W'(file_cnt_tab[d]);
            end
            else
            begin
                dir_key_tab[num_dirs]  = r.dir_key;
                file_cnt_tab[num_dirs] = 0;
                res.dir_slot           = SLOT_W'(num_dirs);
                num_dirs++;
            end
        end
        else if (d < 0)
            res.status = ST_DIR_MISSING;
        else
        begin
            n = file_cnt_tab[d];
            for (i = 0; i < n; i++)
            begin
                if (f < 0 && file_key_tab[d][i] == r.file_key)
                    f = i;
            end
            case (r.operation)
                OP_CREATE_FILE:
                begin
                    // A duplicate is reported even when the directory is full.
                    if (f >= 0)
                        res.status = ST_FILE_EXISTS;
                    else if (n >= TB_MAX_FILES)
                        res.status = ST_DIR_FULL;
                    else
                    begin
                        file_key_tab[d][n] = r.file_key;
                        file_cnt_tab[d]    = n + 1;
                    end
                end
                OP_DELETE_FILE:
                begin
                    // The last file of the directory moves into the hole.
                    if (f < 0)
                        res.status = ST_FILE_MISSING;
                    else
                    begin
                        file_cnt_tab[d]    = n - 1;
                        file_key_tab[d][f] = file_key_tab[d][n-1];
                    end
                end
                default:
                begin
                    if (f < 0)
                        res.status = ST_FILE_MISSING;
                end
            endcase
            res.dir_slot     = SLOT_W'(d);
            res.files_in_dir = FCOUNT_W'(file_cnt_tab[d]);
        end
        return res;
    endfunction

    task automatic note_error(input string what, input logic [63:0] exp_v,
                              input logic [63:0] act_v);
        n_errors++;
        if (n_errors <= 10)
            $display("%0t: %s: expected %0d, got %0d", $time, what, exp_v, act_v);
    endtask

    // Sends one request. The payload goes out at a falling edge and is held
    // until a rising edge finds the block not stalling. The shadow table is
    // updated at that edge. A random gap may follow, in which valid is low
    // and the payload carries noise.
    task automatic send_request(input logic [OP_W-1:0] op,
                                input logic [KEY_W-1:0] dkey,
                                input logic [KEY_W-1:0] fkey);
        tlnt_req_t   item;
        int unsigned gap;
        item.operation = op;
        item.dir_key   = dkey;
        item.file_key  = fkey;
        @(negedge clk);
        req_valid <= 1'b1;
        req       <= item;
        do
            @(posedge clk);
        while (req_stall);
        pending_replies.push_back(run_table_op(item));
        n_sent++;
        gap = 0;
        if (!no_idle && $urandom_range(0, 99) >= 55)
            gap = pause_len();
        if (gap > 0)
        begin
            @(negedge clk);
            req_valid <= 1'b0;
            req       <= {$urandom, $urandom, $urandom, $urandom, 2'($urandom)};
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // Drops valid once a test has sent its last request.
    task automatic release_request();
        @(negedge clk);
        req_valid <= 1'b0;
    endtask

    // Response stall: ready stretches alternate with stall stretches of
    // random length. With no_idle set the block is never stalled.
    initial
    begin : rsp_stall_gen
        int unsigned run_len;
        forever
        begin
            run_len = $urandom_range(1, 12);
            @(negedge clk);
            rsp_stall <= 1'b0;
            repeat (run_len - 1) @(negedge clk);
            if (!no_idle)
            begin
                run_len = pause_len();
                @(negedge clk);
                rsp_stall <= 1'b1;
                repeat (run_len - 1) @(negedge clk);
            end
        end
    end

    // Every response taken at a rising edge is matched against the oldest
    // pending one, field by field.
    always @(posedge clk)
    begin : reply_check
        tlnt_rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_replies.size() == 0)
                note_error("response with nothing pending (status)", 64'(0),
                           64'(rsp.status));
            else
            begin
                want = pending_replies.pop_front();
                n_checked++;
                status_hits[want.status]++;
                if (rsp.status !== want.status)
                    note_error("status", 64'(want.status), 64'(rsp.status));
                if (rsp.dir_slot !== want.dir_slot)
                    note_error("dir_slot", 64'(want.dir_slot), 64'(rsp.dir_slot));
                if (rsp.files_in_dir !== want.files_in_dir)
                    note_error("files_in_dir", 64'(want.files_in_dir),
                               64'(rsp.files_in_dir));
            end
        end
    end

    // Walks through all statuses but table full and dir full on two directories:
    // keys of all zeros and all ones, duplicates, misses, and deletes from the
    // first and a middle slot so that the move of the last file is seen.
    task automatic test_directed();
        logic [KEY_W-1:0] dir_a;
        logic [KEY_W-1:0] dir_b;
        logic [KEY_W-1:0] k1;
        logic [KEY_W-1:0] k2;
        dir_a = '0;
        dir_b = '1;
        k1    = rand_key();
        k2    = rand_key();
        send_request(OP_SEARCH_FILE, dir_a, k1);
        send_request(OP_CREATE_FILE, dir_a, k1);
        send_request(OP_DELETE_FILE, dir_a, k1);
        send_request(OP_CREATE_DIR, dir_a, rand_key());
        send_request(OP_CREATE_DIR, dir_a, rand_key());
        send_request(OP_CREATE_DIR, dir_b, '0);
        dir_list.push_back(dir_a);
        dir_list.push_back(dir_b);
        send_request(OP_CREATE_FILE, dir_a, '0);
        send_request(OP_CREATE_FILE, dir_a, '1);
        send_request(OP_CREATE_FILE, dir_a, k1);
        send_request(OP_CREATE_FILE, dir_a, k2);
        send_request(OP_CREATE_FILE, dir_a, '1);
        send_request(OP_SEARCH_FILE, dir_a, '0);
        send_request(OP_SEARCH_FILE, dir_a, ~k1);
        send_request(OP_DELETE_FILE, dir_a, ~k1);
        send_request(OP_DELETE_FILE, dir_a, '1);
        send_request(OP_SEARCH_FILE, dir_a, k2);
        send_request(OP_SEARCH_FILE, dir_a, '1);
        send_request(OP_DELETE_FILE, dir_a, k2);
        send_request(OP_DELETE_FILE, dir_a, '0);
        send_request(OP_CREATE_FILE, dir_b, k1);
        send_request(OP_SEARCH_FILE, dir_b, k1);
        send_request(OP_CREATE_DIR, dir_b, k1);
        send_request(OP_SEARCH_FILE, rand_key(), k1);
        release_request();
    endtask

    // Fills one directory to its limit, then tries a new file and an
    // existing one, frees one slot, refills it and tries a new file again.
    task automatic test_directory_full();
        logic [KEY_W-1:0] dkey;
        logic [KEY_W-1:0] names [TB_MAX_FILES];
        int unsigned      i;
        dkey = rand_key();
        send_request(OP_CREATE_DIR, dkey, '0);
        dir_list.push_back(dkey);
        for (i = 0; i < TB_MAX_FILES; i++)
        begin
            names[i] = rand_key();
            send_request(OP_CREATE_FILE, dkey, names[i]);
        end
        send_request(OP_CREATE_FILE, dkey, rand_key());
        send_request(OP_CREATE_FILE, dkey, names[TB_MAX_FILES-1]);
        send_request(OP_SEARCH_FILE, dkey, names[TB_MAX_FILES-1]);
        send_request(OP_DELETE_FILE, dkey, names[0]);
        send_request(OP_SEARCH_FILE, dkey, names[TB_MAX_FILES-1]);
        send_request(OP_CREATE_FILE, dkey, names[0]);
        send_request(OP_CREATE_FILE, dkey, rand_key());
        release_request();
    endtask

    // Fills the directory table. After that any create directory request,
    // a duplicate included, reports a full table.
    task automatic test_table_full();
        logic [KEY_W-1:0] dkey;
        while (dir_list.size() < TB_MAX_DIRS)
        begin
            dkey = rand_key();
            send_request(OP_CREATE_DIR, dkey, rand_key());
            dir_list.push_back(dkey);
        end
        send_request(OP_CREATE_DIR, rand_key(), '0);
        send_request(OP_CREATE_DIR, dir_list[0], '1);
        send_request(OP_SEARCH_FILE, dir_list[TB_MAX_DIRS-1], '0);
        release_request();
    endtask

    // Random traffic over the full table. Half of it goes to the first three
    // directories, so those drift up to their limit; file keys come mostly
    // from a small pool. A few requests use unknown directory keys.
    task automatic test_random_traffic(input int unsigned count);
        logic [OP_W-1:0]  op;
        logic [KEY_W-1:0] dkey;
        logic [KEY_W-1:0] fkey;
        int unsigned      r;
        repeat (count)
        begin
            r = $urandom_range(0, 99);
            if ($urandom_range(0, 1) == 0)
                dkey = dir_list[$urandom_range(0, 2)];
            else
                dkey = dir_list[$urandom_range(0, dir_list.size() - 1)];
            if ($urandom_range(0, 9) == 0)
                fkey = rand_key();
            else
                fkey = file_pool[$urandom_range(0, POOL_SIZE - 1)];
            if (r < 42)
                op = OP_CREATE_FILE;
            else if (r < 67)
                op = OP_DELETE_FILE;
            else if (r < 92)
                op = OP_SEARCH_FILE;
            else if (r < 96)
                op = OP_CREATE_DIR;
            else
            begin
                op   = OP_W'($urandom);
                dkey = rand_key();
            end
            send_request(op, dkey, fkey);
        end
        release_request();
    endtask

    initial
    begin : main
        int unsigned i;
        for (i = 0; i < POOL_SIZE; i++)
            file_pool[i] = rand_key();
        file_pool[0] = '0;
        file_pool[1] = '1;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_directory_full();
        test_table_full();
        test_random_traffic(600);
        // A stretch in which neither side pauses.
        no_idle = 1'b1;
        test_random_traffic(150);
        no_idle = 1'b0;
        test_random_traffic(250);

        // Let the block drain; the time limit catches a response that never
        // comes. Then keep the clock running so that a stray extra response
        // would still be seen.
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (120) @(posedge clk);

        $display("Sent %0d requests over %0d directories, checked %0d responses.",
                 n_sent, dir_list.size(), n_checked);
        $write("Status counts: ok %0d, table full %0d, dir exists %0d, ",
               status_hits[ST_OK], status_hits[ST_TABLE_FULL],
               status_hits[ST_DIR_EXISTS]);
        $display("dir missing %0d, file exists %0d, file missing %0d, dir full %0d",
                 status_hits[ST_DIR_MISSING], status_hits[ST_FILE_EXISTS],
                 status_hits[ST_FILE_MISSING], status_hits[ST_DIR_FULL]);
        if (n_errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Time limit: far beyond the slowest correct run.
    initial
    begin : watchdog
        #10_000_000;
        $display("Timed out with %0d responses still pending.", pending_replies.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule
